// ----- hdl/horizontal_line_mirror_unit_assert.svh -----
// assertion macros for the checker file of the line mirror
// no dependencies; expects clk and rst_n in the scope of use
`ifndef HORIZONTAL_LINE_MIRROR_UNIT_ASSERT_SVH
`define HORIZONTAL_LINE_MIRROR_UNIT_ASSERT_SVH

// checked only outside reset
`define HLM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define HLM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/hlm_pkg.sv -----
// shared types and constants of the horizontal line mirror
// no dependencies
package hlm_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PACKED_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 1'd1;

    localparam logic [CFG_DATA_W-1:0] ROW_BYTES_RESET = 13'd4096;

    // operation codes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic emit;
        logic last;
        logic we;
    } hlm_ctrl_t;

endpackage

// ----- hdl/horizontal_line_mirror_unit.sv -----
// path: a mirrored byte reaches m_tdata from the input transaction that causes it
// through the queue register, then the line memory read register
// throughput: one transaction per cycle while the queue has room, held by the line
// memory doing one write and one read each cycle; a 4-entry queue absorbs output stalls
// reset: positions, bank select, drain flag and queue clear; packed_mode to 0,
// row_bytes to 4096; the line memory is not cleared
module horizontal_line_mirror_unit #(
    parameter int MAX_ROW = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hlm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hlm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel_byte
    input  logic [0:0]                    s_tuser,   // [0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast    // last_of_row
);

    localparam int POS_W = $clog2(MAX_ROW);
    localparam int CTRL_W = $bits(hlm_pkg::hlm_ctrl_t);
    localparam int Q_W = CTRL_W + 2 * (POS_W + 1) + 8;

    hlm_pkg::hlm_ctrl_t f_ctrl, b_ctrl;
    logic [POS_W:0]     f_raddr, f_waddr, b_raddr, b_waddr;
    logic [7:0]         f_wdata, b_wdata;
    logic [Q_W-1:0]     q_in, q_out;
    logic               accept;
    logic               q_valid;
    logic               q_pop;

    assign accept = s_tvalid && s_tready;

    hlm_front #(
        .MAX_ROW (MAX_ROW),
        .POS_W   (POS_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .operation  (s_tuser[0]),
        .pixel_byte (s_tdata),
        .ctrl       (f_ctrl),
        .raddr      (f_raddr),
        .waddr      (f_waddr),
        .wdata      (f_wdata)
    );

    assign q_in = {f_ctrl, f_raddr, f_waddr, f_wdata};

    hlm_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (q_in),
        .not_full  (s_tready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    assign {b_ctrl, b_raddr, b_waddr, b_wdata} = q_out;

    hlm_back #(
        .POS_W (POS_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .ctrl     (b_ctrl),
        .raddr    (b_raddr),
        .waddr    (b_waddr),
        .wdata    (b_wdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/hlm_front.sv -----
// front part: config registers, row/drain position tracking, classification
// of each transaction into a memory write and an optional mirrored read; uses hlm_pkg
module hlm_front #(
    parameter int MAX_ROW = 4096,
    parameter int POS_W   = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hlm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hlm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          accept,
    input  logic                          operation,
    input  logic [7:0]                    pixel_byte,
    output hlm_pkg::hlm_ctrl_t            ctrl,
    output logic [POS_W:0]                raddr,
    output logic [POS_W:0]                waddr,
    output logic [7:0]                    wdata
);

    localparam int LEN_W = $clog2(MAX_ROW + 1);
    localparam int CMP_W = (LEN_W > hlm_pkg::CFG_DATA_W) ? LEN_W : hlm_pkg::CFG_DATA_W;

    logic                          packed_mode_reg;
    logic [hlm_pkg::CFG_DATA_W-1:0] row_bytes_reg;
    logic [POS_W-1:0]              write_pos_reg, write_pos_next;
    logic [POS_W-1:0]              read_pos_reg, read_pos_next;
    logic                          fill_bank_reg, fill_bank_next;
    logic                          drain_valid_reg, drain_valid_next;

    logic [CMP_W-1:0] row_ext;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_m1;
    logic [POS_W-1:0] pos;
    logic             last;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] base;
    logic [LEN_W-1:0] wp_inc;
    logic             row_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packed_mode_reg <= 1'b0;
            row_bytes_reg   <= hlm_pkg::ROW_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hlm_pkg::CFG_PACKED_MODE: packed_mode_reg <= cfg_data[0];
                hlm_pkg::CFG_ROW_BYTES:   row_bytes_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective row length
    always_comb
    begin
        row_ext = CMP_W'(row_bytes_reg);
        if (row_ext == '0)
            len_sat = LEN_W'(1);
        else if (row_ext > CMP_W'(MAX_ROW))
            len_sat = LEN_W'(MAX_ROW);
        else
            len_sat = LEN_W'(row_ext);

        if (packed_mode_reg)
        begin
            len = {len_sat[LEN_W-1:2], 2'b00};
            if (len < LEN_W'(4))
                len = LEN_W'(4);
        end
        else
            len = len_sat;
        len_m1 = len - LEN_W'(1);
    end

    // mirrored read position; a position past the end is the last byte
    always_comb
    begin
        if (LEN_W'(read_pos_reg) >= len_m1)
        begin
            pos  = POS_W'(len_m1);
            last = 1'b1;
        end
        else
        begin
            pos  = read_pos_reg;
            last = 1'b0;
        end

        base = POS_W'(len - LEN_W'(4) - LEN_W'({pos[POS_W-1:2], 2'b00}));
        if (packed_mode_reg)
            idx = {base[POS_W-1:2], pos[1] ^ ~pos[0], pos[0]};
        else
            idx = POS_W'(len_m1 - LEN_W'(pos));
    end

    always_comb
    begin
        wp_inc   = LEN_W'(write_pos_reg) + LEN_W'(1);
        row_done = (operation == hlm_pkg::OP_DATA) && (wp_inc >= len);

        write_pos_next   = write_pos_reg;
        read_pos_next    = read_pos_reg;
        fill_bank_next   = fill_bank_reg;
        drain_valid_next = drain_valid_reg;

        if (drain_valid_reg)
        begin
            if (last)
            begin
                drain_valid_next = 1'b0;
                read_pos_next    = '0;
            end
            else
                read_pos_next = pos + POS_W'(1);
        end

        if (operation == hlm_pkg::OP_DATA)
        begin
            write_pos_next = POS_W'(wp_inc);
            // completed row swaps banks and abandons any drain in progress
            if (row_done)
            begin
                fill_bank_next   = ~fill_bank_reg;
                write_pos_next   = '0;
                read_pos_next    = '0;
                drain_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg   <= '0;
            read_pos_reg    <= '0;
            fill_bank_reg   <= 1'b0;
            drain_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            write_pos_reg   <= write_pos_next;
            read_pos_reg    <= read_pos_next;
            fill_bank_reg   <= fill_bank_next;
            drain_valid_reg <= drain_valid_next;
        end
    end

    assign ctrl.emit = drain_valid_reg;
    assign ctrl.last = last;
    assign ctrl.we   = (operation == hlm_pkg::OP_DATA);
    assign raddr     = {~fill_bank_reg, idx};
    assign waddr     = {fill_bank_reg, write_pos_reg};
    assign wdata     = pixel_byte;

endmodule

// ----- hdl/hlm_queue.sv -----
// short flop queue decoupling the front classifier from the line memory
// uses hlm_pkg for the depth
module hlm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(hlm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hlm_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [hlm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign not_full  = (count_reg != CNT_W'(hlm_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

endmodule

// ----- hdl/hlm_back.sv -----
// back part: double-banked line memory and the registered output stage
// uses hlm_pkg for the control struct
module hlm_back #(
    parameter int POS_W = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  hlm_pkg::hlm_ctrl_t ctrl,
    input  logic [POS_W:0]     raddr,
    input  logic [POS_W:0]     waddr,
    input  logic [7:0]         wdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);

    logic [7:0] mem [2**(POS_W+1)];
    logic [7:0] rd_data_reg;
    logic       last_reg;
    logic       m_tvalid_reg;

    // a read waits for a free output slot, a write-only entry never waits
    assign q_pop = q_valid && (!ctrl.emit || !m_tvalid_reg || m_tready);

    // read and write of one transaction hit opposite banks
    always_ff @(posedge clk)
    begin
        if (q_pop && ctrl.we)
            mem[waddr] <= wdata;
        if (q_pop && ctrl.emit)
        begin
            rd_data_reg <= mem[raddr];
            last_reg    <= ctrl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (q_pop && ctrl.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rd_data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- hdl/hlm_checker.sv -----
// port-level checker for the line mirror, bound to the top level
// depends on horizontal_line_mirror_unit_assert.svh
`include "horizontal_line_mirror_unit_assert.svh"

module hlm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // input transactions not yet matched by an output transaction, saturating
    logic [31:0] pending_reg;
    logic        saturated_reg;
    logic        in_xact, out_xact;

    assign in_xact  = s_tvalid && s_tready;
    assign out_xact = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            saturated_reg <= 1'b0;
        end
        else if (!saturated_reg)
        begin
            if (in_xact && !out_xact)
            begin
                if (pending_reg == '1)
                    saturated_reg <= 1'b1;
                else
                    pending_reg <= pending_reg + 32'd1;
            end
            else if (out_xact && !in_xact && pending_reg != '0)
                pending_reg <= pending_reg - 32'd1;
        end
    end

    `HLM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output changed")
    `HLM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "output valid during reset")
    `HLM_ASSERT(a_out_has_cause, m_tvalid && !saturated_reg |-> pending_reg != '0, "output with no input transaction behind it")

endmodule

bind horizontal_line_mirror_unit hlm_checker u_hlm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
